FILE: hdl/pattern_text_tokenizer_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pattern text tokenizer.
// Shared by every module that checks its own logic.
// ----------------------------------------------------------------------------
`ifndef PATTERN_TEXT_TOKENIZER_CORE_DEFINES_SVH
`define PATTERN_TEXT_TOKENIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PTT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PTT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Types, character codes and defaults for the pattern text tokenizer.
// ----------------------------------------------------------------------------
package ptt_pkg;

  // Default field widths.
  localparam int OFFSET_BITS_DEF = 24;
  localparam int LINE_BITS_DEF   = 16;
  localparam int LENGTH_BITS_DEF = 16;

  // Result queue depth; must be a power of two and at least 2.
  localparam int FIFO_DEPTH_DEF  = 4;

  // Token kinds.
  localparam logic [2:0] KIND_END    = 3'd0;
  localparam logic [2:0] KIND_IDENT  = 3'd1;
  localparam logic [2:0] KIND_ARROW  = 3'd2;
  localparam logic [2:0] KIND_STRING = 3'd3;
  localparam logic [2:0] KIND_SINGLE = 3'd4;
  localparam logic [2:0] KIND_ERROR  = 3'd5;

  // Character codes.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_UNDER   = 8'h5F;

  // Lexer modes, one-hot.
  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b0000001,
    MODE_IDENT   = 7'b0000010,
    MODE_DASH    = 7'b0000100,
    MODE_SLASH   = 7'b0001000,
    MODE_COMMENT = 7'b0010000,
    MODE_STRING  = 7'b0100000,
    MODE_HALT    = 7'b1000000
  } mode_t;

  // Letters, digits and underscore.
  function automatic logic word_char(input logic [7:0] c);
    word_char = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                (c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDER);
  endfunction

  // Whitespace that is skipped between tokens.
  function automatic logic blank_char(input logic [7:0] c);
    blank_char = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
                 (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

FILE: hdl/pattern_text_tokenizer_core.sv
// ----------------------------------------------------------------------------
// pattern_text_tokenizer_core
// Streaming lexer, one character per cycle when not stalled; each character gives 0 to 2 tokens.
// A token is written into the result queue when the character that completes it
// is accepted, and shows on the output once it is at the head of the queue. Input
// is held back (ch_stall) while the queue has room for fewer than two tokens, so a
// stalled output, or characters that yield two tokens each, can hold input back.
// Reset (rst, synchronous): idle mode, offset 0, line 1, result queue empty.
// ----------------------------------------------------------------------------
`include "pattern_text_tokenizer_core_defines.svh"

module pattern_text_tokenizer_core #(
  parameter int OFFSET_BITS = ptt_pkg::OFFSET_BITS_DEF,
  parameter int LINE_BITS   = ptt_pkg::LINE_BITS_DEF,
  parameter int LENGTH_BITS = ptt_pkg::LENGTH_BITS_DEF,
  parameter int FIFO_DEPTH  = ptt_pkg::FIFO_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   ch_valid,
  output logic                   ch_stall,
  input  logic [7:0]             ch,
  output logic                   tok_valid,
  input  logic                   tok_stall,
  output logic [2:0]             kind,
  output logic [7:0]             char_code,
  output logic [OFFSET_BITS-1:0] start_offset,
  output logic [LENGTH_BITS-1:0] token_length,
  output logic [LINE_BITS-1:0]   line_number,
  output logic                   last
);

  localparam int RW = 3 + 8 + OFFSET_BITS + LENGTH_BITS + LINE_BITS + 1;

  // Lexer state.
  ptt_pkg::mode_t         mode;
  ptt_pkg::mode_t         mode_next;
  logic [OFFSET_BITS-1:0] char_offset;
  logic [OFFSET_BITS-1:0] char_offset_next;
  logic [LINE_BITS-1:0]   current_line;
  logic [LINE_BITS-1:0]   current_line_next;
  logic [OFFSET_BITS-1:0] pend_start;
  logic [OFFSET_BITS-1:0] pend_start_next;
  logic [LINE_BITS-1:0]   pend_line;
  logic [LINE_BITS-1:0]   pend_line_next;
  logic [LENGTH_BITS-1:0] pend_len;
  logic [LENGTH_BITS-1:0] pend_len_next;

  // Token closed by the current mode, and token started fresh by this character.
  logic                   a_vld;
  logic [2:0]             a_kind;
  logic [7:0]             a_code;
  logic [OFFSET_BITS-1:0] a_start;
  logic [LENGTH_BITS-1:0] a_len;
  logic [LINE_BITS-1:0]   a_line;
  logic                   b_vld;
  logic [2:0]             b_kind;
  logic [7:0]             b_code;
  logic [OFFSET_BITS-1:0] b_start;
  logic [LENGTH_BITS-1:0] b_len;
  logic [LINE_BITS-1:0]   b_line;

  logic                   ch_acc;
  logic                   room2;
  logic [1:0]             push_cnt;
  logic [RW-1:0]          a_data;
  logic [RW-1:0]          b_data;
  logic [RW-1:0]          push_data0;
  logic [RW-1:0]          tok_data;
  logic [LENGTH_BITS-1:0] pend_len_inc;
  logic [OFFSET_BITS-1:0] char_offset_inc;
  logic [LINE_BITS-1:0]   current_line_inc;

  assign ch_stall = !room2;
  assign ch_acc   = ch_valid && !ch_stall;

  // Saturating increments.
  assign pend_len_inc     = (pend_len == '1) ? pend_len : pend_len + LENGTH_BITS'(1);
  assign char_offset_inc  = (char_offset == '1) ? char_offset
                                                : char_offset + OFFSET_BITS'(1);
  assign current_line_inc = (current_line == '1) ? current_line
                                                 : current_line + LINE_BITS'(1);

  // One character of lexing.
  always_comb begin
    logic fresh;
    logic stop;
    fresh             = 1'b0;
    stop              = 1'b0;
    mode_next         = mode;
    char_offset_next  = char_offset;
    current_line_next = current_line;
    pend_start_next   = pend_start;
    pend_line_next    = pend_line;
    pend_len_next     = pend_len;
    a_vld   = 1'b0;
    a_kind  = ptt_pkg::KIND_END;
    a_code  = 8'h00;
    a_start = pend_start;
    a_len   = pend_len;
    a_line  = pend_line;
    b_vld   = 1'b0;
    b_kind  = ptt_pkg::KIND_END;
    b_code  = 8'h00;
    b_start = char_offset;
    b_len   = '0;
    b_line  = current_line;

    // Close or extend the pending token.
    unique case (mode)
      ptt_pkg::MODE_HALT: begin
        stop = 1'b1;
      end
      ptt_pkg::MODE_IDENT: begin
        if (ptt_pkg::word_char(ch)) begin
          pend_len_next = pend_len_inc;
        end else begin
          a_vld     = 1'b1;
          a_kind    = ptt_pkg::KIND_IDENT;
          mode_next = ptt_pkg::MODE_IDLE;
          fresh     = 1'b1;
        end
      end
      ptt_pkg::MODE_DASH: begin
        a_vld     = 1'b1;
        mode_next = ptt_pkg::MODE_IDLE;
        if (ch == ptt_pkg::CH_GT) begin
          a_kind = ptt_pkg::KIND_ARROW;
          a_len  = LENGTH_BITS'(2);
        end else begin
          a_kind = ptt_pkg::KIND_SINGLE;
          a_code = ptt_pkg::CH_DASH;
          a_len  = LENGTH_BITS'(1);
          fresh  = 1'b1;
        end
      end
      ptt_pkg::MODE_SLASH: begin
        if (ch == ptt_pkg::CH_SLASH) begin
          mode_next = ptt_pkg::MODE_COMMENT;
        end else begin
          a_vld     = 1'b1;
          a_kind    = ptt_pkg::KIND_SINGLE;
          a_code    = ptt_pkg::CH_SLASH;
          a_len     = LENGTH_BITS'(1);
          mode_next = ptt_pkg::MODE_IDLE;
          fresh     = 1'b1;
        end
      end
      ptt_pkg::MODE_COMMENT: begin
        if (ch == ptt_pkg::CH_NL || ch == ptt_pkg::CH_NUL) begin
          mode_next = ptt_pkg::MODE_IDLE;
          fresh     = 1'b1;
        end
      end
      ptt_pkg::MODE_STRING: begin
        if (ch == ptt_pkg::CH_QUOTE) begin
          a_vld         = 1'b1;
          a_kind        = ptt_pkg::KIND_STRING;
          a_len         = pend_len_inc;
          pend_len_next = pend_len_inc;
          mode_next     = ptt_pkg::MODE_IDLE;
        end else if (ch == ptt_pkg::CH_NL || ch == ptt_pkg::CH_NUL) begin
          // A cut string is fatal: report it and stop until reset.
          a_vld     = 1'b1;
          a_kind    = ptt_pkg::KIND_ERROR;
          mode_next = ptt_pkg::MODE_HALT;
          stop      = 1'b1;
        end else begin
          pend_len_next = pend_len_inc;
        end
      end
      default: begin
        mode_next = ptt_pkg::MODE_IDLE;
        fresh     = 1'b1;
      end
    endcase

    // Look at this character as the start of something new.
    if (fresh) begin
      priority if (ch == ptt_pkg::CH_NUL) begin
        b_vld             = 1'b1;
        b_kind            = ptt_pkg::KIND_END;
        char_offset_next  = '0;
        current_line_next = LINE_BITS'(1);
        stop              = 1'b1;
      end else if (ptt_pkg::blank_char(ch)) begin
        if (ch == ptt_pkg::CH_NL) begin
          current_line_next = current_line_inc;
        end
      end else if (ptt_pkg::word_char(ch) || ch == ptt_pkg::CH_DASH ||
                   ch == ptt_pkg::CH_SLASH || ch == ptt_pkg::CH_QUOTE) begin
        pend_start_next = char_offset;
        pend_line_next  = current_line;
        pend_len_next   = LENGTH_BITS'(1);
        priority if (ptt_pkg::word_char(ch)) begin
          mode_next = ptt_pkg::MODE_IDENT;
        end else if (ch == ptt_pkg::CH_DASH) begin
          mode_next = ptt_pkg::MODE_DASH;
        end else if (ch == ptt_pkg::CH_SLASH) begin
          mode_next = ptt_pkg::MODE_SLASH;
        end else begin
          mode_next = ptt_pkg::MODE_STRING;
        end
      end else begin
        b_vld  = 1'b1;
        b_kind = ptt_pkg::KIND_SINGLE;
        b_code = ch;
        b_len  = LENGTH_BITS'(1);
      end
    end

    if (!stop) begin
      char_offset_next = char_offset_inc;
    end
  end

  // State registers advance only on an accepted character.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= ptt_pkg::MODE_IDLE;
      char_offset  <= '0;
      current_line <= LINE_BITS'(1);
      pend_start   <= '0;
      pend_line    <= LINE_BITS'(1);
      pend_len     <= '0;
    end else if (ch_acc) begin
      mode         <= mode_next;
      char_offset  <= char_offset_next;
      current_line <= current_line_next;
      pend_start   <= pend_start_next;
      pend_line    <= pend_line_next;
      pend_len     <= pend_len_next;
    end
  end

  // Pack the tokens; the last one of this character carries the last flag.
  assign a_data     = {a_kind, a_code, a_start, a_len, a_line, !b_vld};
  assign b_data     = {b_kind, b_code, b_start, b_len, b_line, 1'b1};
  assign push_data0 = a_vld ? a_data : b_data;
  assign push_cnt   = !ch_acc        ? 2'd0 :
                      (a_vld && b_vld) ? 2'd2 :
                      (a_vld || b_vld) ? 2'd1 : 2'd0;

  ptt_result_fifo #(
    .WIDTH (RW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_cnt   (push_cnt),
    .push_data0 (push_data0),
    .push_data1 (b_data),
    .room2      (room2),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok_data   (tok_data)
  );

  assign {kind, char_code, start_offset, token_length, line_number, last} = tok_data;

  `PTT_ASSERT_NOW(a_halt_silent, clk, rst, mode == ptt_pkg::MODE_HALT, push_cnt == 2'd0, "token emitted while halted")
  `PTT_ASSERT_NEXT(a_error_halts, clk, rst, ch_acc && a_vld && (a_kind == ptt_pkg::KIND_ERROR), mode == ptt_pkg::MODE_HALT, "error did not halt the lexer")
  `PTT_ASSERT_NEXT(a_end_restarts, clk, rst, ch_acc && b_vld && (b_kind == ptt_pkg::KIND_END), (char_offset == '0) && (current_line == LINE_BITS'(1)), "end of text did not restart position")

endmodule

FILE: hdl/ptt_result_fifo.sv
// ----------------------------------------------------------------------------
// ptt_result_fifo
// Small result queue that takes up to two words per cycle and gives one when not stalled.
// ----------------------------------------------------------------------------
`include "pattern_text_tokenizer_core_defines.svh"

module ptt_result_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = ptt_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [1:0]       push_cnt,
  input  logic [WIDTH-1:0] push_data0,
  input  logic [WIDTH-1:0] push_data1,
  output logic             room2,
  output logic             tok_valid,
  input  logic             tok_stall,
  output logic [WIDTH-1:0] tok_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [PW-1:0]    wr_ptr1;
  logic             pop;

  assign pop       = tok_valid && !tok_stall;
  assign tok_valid = (count != '0);
  assign tok_data  = mem[rd_ptr];
  assign room2     = (count <= CW'(DEPTH - 2));
  assign wr_ptr1   = wr_ptr + PW'(1);

  // Occupancy after this cycle's pushes and pop.
  always_comb begin
    count_next = count + CW'(push_cnt) - CW'(pop);
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_cnt);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count_next;
    end
  end

  // Storage; the second word lands right after the first.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push_data0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr1] <= push_data1;
    end
  end

  `PTT_ASSERT_NOW(a_count_max, clk, rst, 1'b1, count <= CW'(DEPTH), "result queue overfilled")
  `PTT_ASSERT_NOW(a_push_room, clk, rst, push_cnt != 2'd0, room2, "push without room")
  `PTT_ASSERT_NEXT(a_pop_only, clk, rst, pop && (push_cnt == 2'd0), count == $past(count) - CW'(1), "pop did not drain one word")

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Pattern text tokenizer testbench
// Streams characters into pattern_text_tokenizer_core and checks every token
// against an in-bench lexer model. Both sides idle and stall at random, and
// the run covers directed corner cases, many lines and a long identifier, a
// long output hold-off, random text, and a final unterminated string.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One token as it leaves the block.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  char_code;
    logic [23:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic        last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        ch_valid = 1'b0;
  logic        ch_stall;
  logic [7:0]  ch = 8'h00;
  logic        tok_valid;
  logic        tok_stall = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  char_code;
  logic [23:0] start_offset;
  logic [15:0] token_length;
  logic [15:0] line_number;
  logic        last;

  // Lexer model state.
  ptt_pkg::mode_t lex_mode = ptt_pkg::MODE_IDLE;
  logic [23:0]    text_pos = '0;
  logic [15:0]    line_no = 16'd1;
  logic [23:0]    tok_start = '0;
  logic [15:0]    tok_line = 16'd1;
  logic [15:0]    tok_len = '0;

  token_t expected_tokens[$];
  int     mismatch_count = 0;
  int     chars_sent = 0;
  int     hold_cycles = 0;
  bit     idle_on = 1'b0;
  bit     quiet = 1'b0;

  pattern_text_tokenizer_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .ch_valid     (ch_valid),
    .ch_stall     (ch_stall),
    .ch           (ch),
    .tok_valid    (tok_valid),
    .tok_stall    (tok_stall),
    .kind         (kind),
    .char_code    (char_code),
    .start_offset (start_offset),
    .token_length (token_length),
    .line_number  (line_number),
    .last         (last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Letters, digits and underscore continue an identifier.
  function automatic bit is_name(input logic [7:0] c);
    return (c >= "0" && c <= "9") || c == ptt_pkg::CH_UNDER ||
           ((c | 8'h20) >= "a" && (c | 8'h20) <= "z");
  endfunction

  // Tab through carriage return are contiguous codes.
  function automatic bit is_space(input logic [7:0] c);
    return c == ptt_pkg::CH_SPACE || (c >= ptt_pkg::CH_TAB && c <= ptt_pkg::CH_CR);
  endfunction

  function automatic token_t make_token(input logic [2:0] k, input logic [7:0] code,
                                        input logic [23:0] s, input logic [15:0] n,
                                        input logic [15:0] l);
    token_t t;
    t = '{k, code, s, n, l, 1'b0};
    return t;
  endfunction

  // Advance the lexer model by one character and queue the tokens it yields.
  function automatic void lex_char(input logic [7:0] c);
    token_t step_q[$];
    token_t t;
    bit     restart;
    bit     bump_pos;
    restart = 1'b0;
    bump_pos = 1'b1;
    if (lex_mode == ptt_pkg::MODE_HALT) return;
    case (lex_mode)
      ptt_pkg::MODE_IDENT: begin
        if (is_name(c)) begin
          if (tok_len != 16'hFFFF) tok_len = tok_len + 1'b1;
        end else begin
          step_q.push_back(make_token(ptt_pkg::KIND_IDENT, 8'h00, tok_start, tok_len,
                                      tok_line));
          lex_mode = ptt_pkg::MODE_IDLE;
          restart = 1'b1;
        end
      end
      ptt_pkg::MODE_DASH: begin
        if (c == ptt_pkg::CH_GT) begin
          step_q.push_back(make_token(ptt_pkg::KIND_ARROW, 8'h00, tok_start, 16'd2,
                                      tok_line));
        end else begin
          step_q.push_back(make_token(ptt_pkg::KIND_SINGLE, ptt_pkg::CH_DASH, tok_start,
                                      16'd1, tok_line));
          restart = 1'b1;
        end
        lex_mode = ptt_pkg::MODE_IDLE;
      end
      ptt_pkg::MODE_SLASH: begin
        if (c == ptt_pkg::CH_SLASH) begin
          lex_mode = ptt_pkg::MODE_COMMENT;
        end else begin
          step_q.push_back(make_token(ptt_pkg::KIND_SINGLE, ptt_pkg::CH_SLASH, tok_start,
                                      16'd1, tok_line));
          lex_mode = ptt_pkg::MODE_IDLE;
          restart = 1'b1;
        end
      end
      ptt_pkg::MODE_COMMENT: begin
        if (c == ptt_pkg::CH_NL || c == ptt_pkg::CH_NUL) begin
          lex_mode = ptt_pkg::MODE_IDLE;
          restart = 1'b1;
        end
      end
      ptt_pkg::MODE_STRING: begin
        if (c == ptt_pkg::CH_QUOTE) begin
          if (tok_len != 16'hFFFF) tok_len = tok_len + 1'b1;
          step_q.push_back(make_token(ptt_pkg::KIND_STRING, 8'h00, tok_start, tok_len,
                                      tok_line));
          lex_mode = ptt_pkg::MODE_IDLE;
        end else if (c == ptt_pkg::CH_NL || c == ptt_pkg::CH_NUL) begin
          // A cut string is fatal: the block stops here for good.
          step_q.push_back(make_token(ptt_pkg::KIND_ERROR, 8'h00, tok_start, tok_len,
                                      tok_line));
          lex_mode = ptt_pkg::MODE_HALT;
          bump_pos = 1'b0;
        end else begin
          if (tok_len != 16'hFFFF) tok_len = tok_len + 1'b1;
        end
      end
      default: begin
        lex_mode = ptt_pkg::MODE_IDLE;
        restart = 1'b1;
      end
    endcase

    // The character was not consumed by a pending token, so lex it fresh.
    if (restart) begin
      if (c == ptt_pkg::CH_NUL) begin
        step_q.push_back(make_token(ptt_pkg::KIND_END, 8'h00, text_pos, 16'd0, line_no));
        text_pos = '0;
        line_no = 16'd1;
        bump_pos = 1'b0;
      end else if (is_space(c)) begin
        if (c == ptt_pkg::CH_NL && line_no != 16'hFFFF) line_no = line_no + 1'b1;
      end else if (is_name(c) || c == ptt_pkg::CH_DASH || c == ptt_pkg::CH_SLASH ||
                   c == ptt_pkg::CH_QUOTE) begin
        if (is_name(c)) lex_mode = ptt_pkg::MODE_IDENT;
        else if (c == ptt_pkg::CH_DASH) lex_mode = ptt_pkg::MODE_DASH;
        else if (c == ptt_pkg::CH_SLASH) lex_mode = ptt_pkg::MODE_SLASH;
        else lex_mode = ptt_pkg::MODE_STRING;
        tok_start = text_pos;
        tok_line = line_no;
        tok_len = 16'd1;
      end else begin
        step_q.push_back(make_token(ptt_pkg::KIND_SINGLE, c, text_pos, 16'd1, line_no));
      end
    end

    if (bump_pos && text_pos != 24'hFFFFFF) text_pos = text_pos + 1'b1;
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) begin
      t = step_q[i];
      expected_tokens.push_back(t);
    end
  endfunction

  // Offer one character word, wait for it to be taken, then maybe idle.
  task automatic push_char(input logic [7:0] c);
    int gap;
    ch <= c;
    ch_valid <= 1'b1;
    do @(posedge clk); while (ch_stall);
    lex_char(c);
    chars_sent++;
    if (idle_on && !quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      ch_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  function automatic logic [7:0] rand_byte_except(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == a || c == b);
    return c;
  endfunction

  function automatic logic [7:0] rand_name_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 10) return 8'(r) + "0";
    if (r < 36) return 8'(r - 10) + "A";
    if (r < 62) return 8'(r - 36) + "a";
    return ptt_pkg::CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 5))
      0: return ptt_pkg::CH_SPACE;
      1: return ptt_pkg::CH_TAB;
      2: return ptt_pkg::CH_NL;
      3: return ptt_pkg::CH_VT;
      4: return ptt_pkg::CH_FF;
      default: return ptt_pkg::CH_CR;
    endcase
  endfunction

  // Every token kind but the error, every blank but space, high bytes and the ways a zero ends text.
  task automatic test_directed();
    push_text("a_9->b-x/y//c\n\"q\"");
    push_char(8'h80);
    push_char(ptt_pkg::CH_TAB);
    push_char(ptt_pkg::CH_VT);
    push_char(ptt_pkg::CH_FF);
    push_char(ptt_pkg::CH_CR);
    push_char(8'hFF);
    push_char(ptt_pkg::CH_NUL);
    push_char(ptt_pkg::CH_DASH);
    push_char(ptt_pkg::CH_NUL);
    push_char(ptt_pkg::CH_SLASH);
    push_char(ptt_pkg::CH_NUL);
    push_text("//");
    push_char(ptt_pkg::CH_NUL);
  endtask

  // A run of newlines, then a long identifier.
  task automatic test_lines_and_long_name();
    idle_on = 1'b0;
    repeat (20) push_char(ptt_pkg::CH_NL);
    push_char("x");
    push_char(ptt_pkg::CH_NUL);
    repeat (30) push_char("a");
    push_char(ptt_pkg::CH_SPACE);
    push_char(ptt_pkg::CH_NUL);
    idle_on = 1'b1;
  endtask

  // Output held off for a long stretch while input keeps coming.
  task automatic test_output_backpressure();
    idle_on = 1'b0;
    hold_cycles = 120;
    repeat (20) begin
      push_char(";");
      push_char(",");
    end
    idle_on = 1'b1;
  endtask

  // Mostly well-formed tokens with random content, some noise and ends.
  task automatic random_text(input int count);
    int stop;
    int n;
    stop = chars_sent + count;
    while (chars_sent < stop) begin
      if ($urandom_range(0, 9) == 0) quiet = ($urandom_range(0, 2) == 0);
      case ($urandom_range(0, 14))
        0, 1, 2, 3: begin
          n = $urandom_range(1, 8);
          repeat (n) push_char(rand_name_char());
        end
        4: push_text("->");
        5: push_char(ptt_pkg::CH_DASH);
        6: push_char(ptt_pkg::CH_SLASH);
        7: begin
          push_text("//");
          n = $urandom_range(0, 6);
          repeat (n) push_char(rand_byte_except(ptt_pkg::CH_NL, ptt_pkg::CH_NL));
          push_char(ptt_pkg::CH_NL);
        end
        8, 9: begin
          push_char(ptt_pkg::CH_QUOTE);
          n = $urandom_range(0, 6);
          repeat (n) push_char(rand_byte_except(ptt_pkg::CH_QUOTE, ptt_pkg::CH_NL));
          push_char(ptt_pkg::CH_QUOTE);
        end
        10, 11: push_char(rand_blank());
        12, 13: push_char(rand_byte_except(ptt_pkg::CH_QUOTE, ptt_pkg::CH_QUOTE));
        default: push_char(ptt_pkg::CH_NUL);
      endcase
    end
    quiet = 1'b0;
  endtask

  task automatic test_random_text();
    idle_on = 1'b1;
    random_text(350);
    // The closing stretch runs with no idling on either side.
    idle_on = 1'b0;
    random_text(100);
  endtask

  // A string cut by a newline or a zero; the block must then stay silent.
  task automatic test_unterminated_string();
    push_char(ptt_pkg::CH_NUL);
    push_text("\"ab");
    push_char($urandom_range(0, 1) ? ptt_pkg::CH_NL : ptt_pkg::CH_NUL);
    push_char("x");
    push_char(";");
    push_char(ptt_pkg::CH_QUOTE);
  endtask

  // Output side: random stall bursts, plus a long hold when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        tok_stall <= 1'b1;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        tok_stall <= 1'b0;
      end else if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
        tok_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        tok_stall <= 1'b0;
      end
    end
  end

  // Compare each accepted token word with the oldest expected one.
  always @(posedge clk) begin : check_tokens
    token_t got;
    token_t want;
    if (!rst && tok_valid && !tok_stall) begin
      got = '{kind, char_code, start_offset, token_length, line_number, last};
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token kind=%0d char=%02h start=%0d len=%0d line=%0d last=%0b",
                 $time, got.kind, got.char_code, got.start_offset, got.token_length,
                 got.line_number, got.last);
        mismatch_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (got !== want) begin
          $display("%0t: token mismatch", $time);
          $display("  expected kind=%0d char=%02h start=%0d len=%0d line=%0d last=%0b",
                   want.kind, want.char_code, want.start_offset, want.token_length,
                   want.line_number, want.last);
          $display("  actual   kind=%0d char=%02h start=%0d len=%0d line=%0d last=%0b",
                   got.kind, got.char_code, got.start_offset, got.token_length,
                   got.line_number, got.last);
          mismatch_count++;
        end
      end
    end
  end

  // Hard limit on run length.
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_lines_and_long_name();
    test_output_backpressure();
    test_random_text();
    test_unterminated_string();
    ch_valid <= 1'b0;

    // Drain outstanding tokens, then keep watching for strays.
    for (int w = 0; w < 20000 && expected_tokens.size() > 0; w++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_tokens.size() > 0) begin
      $display("%0t: %0d expected tokens never arrived, next kind=%0d start=%0d",
               $time, expected_tokens.size(), expected_tokens[0].kind,
               expected_tokens[0].start_offset);
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: pattern_text_tokenizer_core.f
+incdir+hdl
hdl/ptt_pkg.sv
hdl/ptt_result_fifo.sv
hdl/pattern_text_tokenizer_core.sv
sim/testbench.sv
